[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/dcpp_pkg.sv]
// ----------------------------------------------------------------------------
// dcpp_pkg
// types and constants of the diagonal prefix cross-product block
// ----------------------------------------------------------------------------
package dcpp_pkg;

   localparam int SAMPLE_W = 16;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int VALUE_W  = 40;
   localparam int IDX_W    = 6;
   localparam int CMD_W    = 2;

   // item command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_LEFT  = 2'd1,
      CMD_RIGHT = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_EMIT
   } state_type;

   // controller strobes common to all cells
   typedef struct packed {
      logic clear;
      logic load;
      logic mul;
      logic add;
      logic shift;
   } ctrl_type;

   // strobes as seen by one cell
   typedef struct packed {
      logic clear;
      logic load;
      logic mul;
      logic add;
      logic capture;
      logic shift;
   } cell_ctrl_type;

endpackage

[hdl/dcpp_cell.sv]
// ----------------------------------------------------------------------------
// dcpp_cell
// one matrix column: left sample, previous-row entry and output shift stage
// ----------------------------------------------------------------------------
module dcpp_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dcpp_pkg::cell_ctrl_type               ctrl,
   input  logic signed [dcpp_pkg::SAMPLE_W-1:0]  x_sample,
   input  logic signed [dcpp_pkg::SAMPLE_W-1:0]  y_sample,
   input  logic signed [dcpp_pkg::VALUE_W-1:0]   d_left,
   output logic signed [dcpp_pkg::VALUE_W-1:0]   d_out,
   input  logic signed [dcpp_pkg::VALUE_W-1:0]   o_right,
   output logic signed [dcpp_pkg::VALUE_W-1:0]   o_out
);

   logic signed [dcpp_pkg::SAMPLE_W-1:0] x_ff;
   logic signed [dcpp_pkg::PROD_W-1:0]   prod_ff;
   logic signed [dcpp_pkg::VALUE_W-1:0]  d_ff;
   logic signed [dcpp_pkg::VALUE_W-1:0]  o_ff;
   logic signed [dcpp_pkg::VALUE_W-1:0]  sum_in;

   // diagonal step: left neighbor's old entry plus this column's product
   assign sum_in = d_left
                 + {{(dcpp_pkg::VALUE_W-dcpp_pkg::PROD_W){prod_ff[dcpp_pkg::PROD_W-1]}},
                    prod_ff};

   // left sample and product
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         x_ff <= x_sample;
      end
      if (ctrl.mul) begin
         prod_ff <= x_ff * y_sample;
      end
   end

   // previous-row entry, zero after reset and start
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         d_ff <= '0;
      end else if (ctrl.add) begin
         d_ff <= sum_in;
      end
   end

   // output shift stage toward the head of the chain
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         o_ff <= sum_in;
      end else if (ctrl.shift) begin
         o_ff <= o_right;
      end
   end

   assign d_out = d_ff;
   assign o_out = o_ff;

endmodule

[hdl/dcpp_ctrl.sv]
// ----------------------------------------------------------------------------
// dcpp_ctrl
// command decode, left length, row sequencing and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcpp_ctrl #(
   parameter int MAX_LEN = 63
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic signed [dcpp_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic [dcpp_pkg::CMD_W-1:0]            req_command,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic signed [dcpp_pkg::VALUE_W-1:0]   rsp_value,
   output logic [dcpp_pkg::IDX_W-1:0]            rsp_index,
   output logic                                  rsp_last,
   input  logic signed [dcpp_pkg::VALUE_W-1:0]   o_head,
   output dcpp_pkg::ctrl_type                    ctrl,
   output logic [dcpp_pkg::IDX_W-1:0]            count,
   output logic signed [dcpp_pkg::SAMPLE_W-1:0]  y_sample
);

   dcpp_pkg::state_type                  state_ff, state_in;
   dcpp_pkg::cmd_type                    cmd;
   logic [dcpp_pkg::IDX_W-1:0]           count_ff;
   logic [dcpp_pkg::IDX_W-1:0]           idx_ff;
   logic signed [dcpp_pkg::SAMPLE_W-1:0] y_ff;
   logic signed [dcpp_pkg::VALUE_W-1:0]  value_ff;
   logic                                 req_acc;
   logic                                 rsp_acc;
   logic                                 full;
   logic                                 last;

   assign cmd     = dcpp_pkg::cmd_type'(req_command);
   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign full    = (count_ff >= dcpp_pkg::IDX_W'(MAX_LEN));
   assign last    = (idx_ff == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dcpp_pkg::ST_IDLE: begin
            if (req_acc && cmd == dcpp_pkg::CMD_RIGHT) begin
               state_in = dcpp_pkg::ST_MUL;
            end
         end
         dcpp_pkg::ST_MUL:  state_in = dcpp_pkg::ST_ADD;
         dcpp_pkg::ST_ADD:  state_in = dcpp_pkg::ST_EMIT;
         dcpp_pkg::ST_EMIT: begin
            if (rsp_acc && last) begin
               state_in = dcpp_pkg::ST_IDLE;
            end
         end
         default: state_in = dcpp_pkg::ST_IDLE;
      endcase
   end

   // outputs and cell strobes
   always_comb begin
      req_tready = (state_ff == dcpp_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == dcpp_pkg::ST_EMIT);
      ctrl.clear = req_acc && cmd == dcpp_pkg::CMD_START;
      ctrl.load  = req_acc && cmd == dcpp_pkg::CMD_LEFT && !full;
      ctrl.mul   = (state_ff == dcpp_pkg::ST_MUL);
      ctrl.add   = (state_ff == dcpp_pkg::ST_ADD);
      ctrl.shift = rsp_acc;
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcpp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // left length
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         count_ff <= '0;
      end else if (ctrl.load) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // right sample of the current row
   always_ff @(posedge clock) begin
      if (req_acc && cmd == dcpp_pkg::CMD_RIGHT) begin
         y_ff <= req_sample;
      end
   end

   // result register: column zero first, then the cell chain head
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (ctrl.add) begin
         idx_ff <= '0;
      end else if (rsp_acc) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.add) begin
         value_ff <= '0;
      end else if (rsp_acc) begin
         value_ff <= o_head;
      end
   end

   assign rsp_value = value_ff;
   assign rsp_index = idx_ff;
   assign rsp_last  = last;
   assign count     = count_ff;
   assign y_sample  = y_ff;

   // checks
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= dcpp_pkg::IDX_W'(MAX_LEN))
   `ASSERT_IMPLIES(a_index_range, clock, reset, rsp_tvalid, idx_ff <= count_ff)
   `ASSERT_IMPLIES(a_col0_zero, clock, reset, rsp_tvalid && idx_ff == '0, value_ff == '0)
   `ASSERT_NEXT(a_row_step, clock, reset, rsp_acc && !last, rsp_tvalid && idx_ff == $past(idx_ff) + 1'b1)
   `ASSERT_NEXT(a_row_done, clock, reset, rsp_acc && last, req_tready && !rsp_tvalid)

endmodule

[hdl/diagonal_cross_product_prefix.sv]
// ----------------------------------------------------------------------------
// diagonal_cross_product_prefix
// diagonal prefix cross-product matrix, one row per right sample
// ----------------------------------------------------------------------------
// Items carry a command in req_tuser: start clears the left series and the
// kept row, left appends a sample (ignored once MAX_LEN are stored), right
// emits row j of d(i,j) = d(i-1,j-1) + x[i-1]*y[j-1] as n+1 result items,
// i = 0..n, with tlast on i = n. For a right item, every column cell first
// forms its 16x16 product, then the diagonal add runs, then column zero and
// the per-cell output chain are sent one result per cycle while rsp_tready
// is high. The block takes the next item in the cycle after the row's last
// result is taken, so it takes no new item while a row is being emitted.
// ----------------------------------------------------------------------------
module diagonal_cross_product_prefix #(
   parameter int MAX_LEN = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [39:0] value, [45:40] left_index, zero pad
   output logic        rsp_tlast
);

   dcpp_pkg::ctrl_type                   ctrl;
   logic [dcpp_pkg::IDX_W-1:0]           count;
   logic signed [dcpp_pkg::SAMPLE_W-1:0] y_sample;
   logic signed [dcpp_pkg::VALUE_W-1:0]  rsp_value;
   logic [dcpp_pkg::IDX_W-1:0]           rsp_index;
   logic signed [dcpp_pkg::VALUE_W-1:0]  d_bus [MAX_LEN];
   logic signed [dcpp_pkg::VALUE_W-1:0]  o_bus [MAX_LEN];

   dcpp_ctrl #(
      .MAX_LEN (MAX_LEN)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_sample  (req_tdata),
      .req_command (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_value   (rsp_value),
      .rsp_index   (rsp_index),
      .rsp_last    (rsp_tlast),
      .o_head      (o_bus[0]),
      .ctrl        (ctrl),
      .count       (count),
      .y_sample    (y_sample)
   );

   // chain of column cells, cell k holds column k+1
   for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      dcpp_pkg::cell_ctrl_type              cell_ctrl;
      logic signed [dcpp_pkg::VALUE_W-1:0]  d_left;
      logic signed [dcpp_pkg::VALUE_W-1:0]  o_right;

      // per-cell strobes: write slot and active columns follow the left length
      always_comb begin
         cell_ctrl.clear   = ctrl.clear;
         cell_ctrl.load    = ctrl.load && (count == dcpp_pkg::IDX_W'(k));
         cell_ctrl.mul     = ctrl.mul;
         cell_ctrl.add     = ctrl.add && (dcpp_pkg::IDX_W'(k) < count);
         cell_ctrl.capture = ctrl.add;
         cell_ctrl.shift   = ctrl.shift;
      end

      if (k == 0) begin : g_first
         assign d_left = '0;
      end else begin : g_inner
         assign d_left = d_bus[k-1];
      end

      if (k == MAX_LEN - 1) begin : g_tail
         assign o_right = '0;
      end else begin : g_body
         assign o_right = o_bus[k+1];
      end

      dcpp_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .x_sample (req_tdata),
         .y_sample (y_sample),
         .d_left   (d_left),
         .d_out    (d_bus[k]),
         .o_right  (o_right),
         .o_out    (o_bus[k])
      );
   end

   // result packing
   assign rsp_tdata = {2'b00, rsp_index, rsp_value};

endmodule
